[hw/rtl/pbg_pkg.sv]
// Shared types, widths and register codes for the pointer ballistics gain block.
// No dependencies; every other file in hw/rtl but pbg_checker imports this package.
package pbg_pkg;

  localparam int CW        = 16;  // mouse count width
  localparam int OFB       = 8;   // output fraction bits
  localparam int GAIN_FRAC = 16;

  localparam int MUL_W = 7;
  localparam int DIV_W = 16;
  localparam int STR_W = 9;
  localparam int PT_W  = 16;

  // Speed root, Q.8
  localparam int RT_W   = CW + 9;
  localparam int RT_PER = 5;
  localparam int RT_STG = (RT_W + RT_PER - 1) / RT_PER;

  // Scaled speed, Q.16
  localparam int XIN_W   = 32;
  localparam int XN_W    = RT_W + MUL_W + 11;
  localparam int DIV_PER = 4;
  localparam int XD_STG  = (XIN_W + DIV_PER - 1) / DIV_PER;

  // Curve interpolation
  localparam int XS_W   = PT_W + 8;
  localparam int NUM_W  = PT_W + XIN_W;
  localparam int CQ_W   = NUM_W - 8;
  localparam int CD_STG = (CQ_W + DIV_PER - 1) / DIV_PER;
  localparam int YQ_W   = CQ_W + 2;
  localparam int MAG_W  = CQ_W + 1;

  // Curve gain
  localparam int P_W    = MAG_W + PT_W + MUL_W;
  localparam int D_W    = PT_W + XIN_W;
  localparam int CG_SH  = 19;
  localparam int GQ_W   = 29;
  localparam int GD_STG = (GQ_W + DIV_PER - 1) / DIV_PER;
  localparam int CG_W   = GQ_W + 1;
  localparam int GAIN_W = 33;
  localparam int OUT_W  = 32;

  // Configuration register index codes
  localparam int RIDX_W = 3;
  localparam logic [RIDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [RIDX_W-1:0] REG_MULT     = 3'd1;
  localparam logic [RIDX_W-1:0] REG_DIVISOR  = 3'd2;
  localparam logic [RIDX_W-1:0] REG_STRENGTH = 3'd3;
  localparam logic [RIDX_W-1:0] REG_XPTS     = 3'd4;
  localparam logic [RIDX_W-1:0] REG_YPTS     = 3'd5;
  localparam logic [RIDX_W-1:0] REG_YORG     = 3'd6;

  typedef struct packed {
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
  } pbg_side_t;

  typedef struct packed {
    logic             enable;
    logic [MUL_W-1:0] mult;
    logic [DIV_W-1:0] divisor;
    logic [STR_W-1:0] strength;
    logic [63:0]      xpts;
    logic [63:0]      ypts;
    logic [PT_W-1:0]  yorg;
  } pbg_cfg_t;

  function automatic logic [MUL_W-1:0] eff_mult(input pbg_cfg_t c);
    return (c.mult == '0) ? MUL_W'(1) : c.mult;
  endfunction

  function automatic logic [DIV_W-1:0] eff_div(input pbg_cfg_t c);
    return (c.divisor == '0) ? DIV_W'(1) : c.divisor;
  endfunction

endpackage

[hw/rtl/pbg_root.sv]
// Report speed: squares the counts and takes the Q.8 square root digit by digit.
// Depends on pbg_pkg.
module pbg_root import pbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              i_valid,
  input  pbg_side_t         i_side,
  output logic              o_valid,
  output pbg_side_t         o_side,
  output logic [RT_W-1:0]   o_root
);
  localparam int RAD_W = 2 * RT_W;
  localparam int REM_W = RT_W + 3;
  localparam int NSTG  = RT_STG + 1;

  logic [NSTG-1:0]   v_r;
  pbg_side_t         side_r [NSTG];
  logic [RAD_W-1:0]  rad_r  [NSTG];
  logic [REM_W-1:0]  rem_r  [NSTG];
  logic [RT_W-1:0]   root_r [NSTG];

  logic [CW-1:0]     ax, ay;
  logic [2*CW:0]     sq;

  always_comb begin
    ax = i_side.dx[CW-1] ? CW'(-i_side.dx) : CW'(i_side.dx);
    ay = i_side.dy[CW-1] ? CW'(-i_side.dy) : CW'(i_side.dy);
    sq = ((2*CW+1)'(ax) * (2*CW+1)'(ax)) + ((2*CW+1)'(ay) * (2*CW+1)'(ay));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= i_side;
      rad_r[0]  <= RAD_W'({sq, 16'b0});
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < RT_STG; s++) begin : g_st
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem, tv;
    logic [RT_W-1:0]  rt;

    always_comb begin
      rad = rad_r[s];
      rem = rem_r[s];
      rt  = root_r[s];
      tv  = '0;
      for (int k = 0; k < RT_PER; k++) begin
        if (s * RT_PER + k < RT_W) begin
          rem = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
          rad = {rad[RAD_W-3:0], 2'b00};
          tv  = REM_W'({rt, 2'b01});
          if (rem >= tv) begin
            rem = rem - tv;
            rt  = {rt[RT_W-2:0], 1'b1};
          end else begin
            rt  = {rt[RT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s+1] <= side_r[s];
        rad_r[s+1]  <= rad;
        rem_r[s+1]  <= rem;
        root_r[s+1] <= rt;
      end
    end
  end

  assign o_valid = v_r[NSTG-1];
  assign o_side  = side_r[NSTG-1];
  assign o_root  = root_r[NSTG-1];

endmodule

[hw/rtl/pbg_scale.sv]
// Curve input: speed * multiplier * 2048 / divisor, saturated to 32 bits.
// Depends on pbg_pkg; restoring divider, DIV_PER quotient bits per stage.
module pbg_scale import pbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  pbg_cfg_t          cfg,
  input  logic              i_valid,
  input  pbg_side_t         i_side,
  input  logic [RT_W-1:0]   i_root,
  output logic              o_valid,
  output pbg_side_t         o_side,
  output logic [XIN_W-1:0]  o_xin
);
  localparam int NSTG = XD_STG + 1;
  localparam int HI_W = XN_W - XIN_W;
  localparam int RM_W = DIV_W + 1;

  logic [NSTG-1:0]   v_r;
  pbg_side_t         side_r [NSTG];
  logic              sat_r  [NSTG];
  logic [RM_W-1:0]   rem_r  [NSTG];
  logic [XIN_W-1:0]  lo_r   [NSTG];

  logic [DIV_W-1:0]        d;
  logic [MUL_W-1:0]        m;
  logic [RT_W+MUL_W-1:0]   p;
  logic [XN_W-1:0]         n;
  logic [HI_W-1:0]         hi;
  logic                    sat0;

  always_comb begin
    d    = eff_div(cfg);
    m    = eff_mult(cfg);
    p    = (RT_W+MUL_W)'(i_root) * (RT_W+MUL_W)'(m);
    n    = {p, 11'b0};
    hi   = n[XN_W-1:XIN_W];
    sat0 = (32'(hi) >= 32'(d));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= i_side;
      sat_r[0]  <= sat0;
      rem_r[0]  <= sat0 ? '0 : RM_W'(hi);
      lo_r[0]   <= n[XIN_W-1:0];
    end
  end

  for (genvar s = 0; s < XD_STG; s++) begin : g_st
    logic [RM_W-1:0]  rem;
    logic [XIN_W-1:0] lo;

    always_comb begin
      rem = rem_r[s];
      lo  = lo_r[s];
      for (int k = 0; k < DIV_PER; k++) begin
        if (s * DIV_PER + k < XIN_W) begin
          rem = {rem[RM_W-2:0], lo[XIN_W-1]};
          lo  = {lo[XIN_W-2:0], 1'b0};
          if (rem >= {1'b0, d}) begin
            rem   = rem - {1'b0, d};
            lo[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s+1] <= side_r[s];
        sat_r[s+1]  <= sat_r[s];
        rem_r[s+1]  <= rem;
        lo_r[s+1]   <= lo;
      end
    end
  end

  assign o_valid = v_r[NSTG-1];
  assign o_side  = side_r[NSTG-1];
  assign o_xin   = sat_r[NSTG-1] ? '1 : lo_r[NSTG-1];

endmodule

[hw/rtl/pbg_curve.sv]
// Five-point piecewise-linear curve: segment pick, slope product, divide, offset.
// Depends on pbg_pkg; quotient truncates toward zero.
module pbg_curve import pbg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  pbg_cfg_t                cfg,
  input  logic                    i_valid,
  input  pbg_side_t               i_side,
  input  logic [XIN_W-1:0]        i_xin,
  output logic                    o_valid,
  output pbg_side_t               o_side,
  output logic [XIN_W-1:0]        o_xin,
  output logic signed [YQ_W-1:0]  o_yq
);
  localparam int NSTG = CD_STG + 3;
  localparam int RM_W = XS_W + 1;

  logic [NSTG-1:0] v_r;

  // segment pick
  logic [XS_W-1:0]   xs [5];
  logic [PT_W-1:0]   ys [5];
  logic [XS_W:0]     segspan [4];
  logic [PT_W:0]     segdy   [4];
  logic              found;
  logic [XS_W:0]     sel_span;
  logic [PT_W:0]     sel_dy;
  logic [PT_W-1:0]   sel_base;
  logic [XS_W-1:0]   sel_tref;
  logic              span_ok;

  pbg_side_t         a_side_r;
  logic [XIN_W-1:0]  a_xin_r, a_t_r;
  logic [PT_W-1:0]   a_base_r, a_dyabs_r;
  logic              a_neg_r, a_ok_r;
  logic [XS_W-1:0]   a_span_r;

  pbg_side_t         side_r [CD_STG+1];
  logic [XIN_W-1:0]  xin_r  [CD_STG+1];
  logic [PT_W-1:0]   base_r [CD_STG+1];
  logic              neg_r  [CD_STG+1];
  logic [XS_W-1:0]   span_r [CD_STG+1];
  logic [RM_W-1:0]   rem_r  [CD_STG+1];
  logic [CQ_W-1:0]   lo_r   [CD_STG+1];

  pbg_side_t               f_side_r;
  logic [XIN_W-1:0]        f_xin_r;
  logic signed [YQ_W-1:0]  f_yq_r;

  logic [NUM_W-1:0]        num;
  logic signed [YQ_W-1:0]  qs, yq;

  always_comb begin
    xs[0] = '0;
    ys[0] = cfg.yorg;
    for (int i = 1; i < 5; i++) begin
      xs[i] = {cfg.xpts[16*(i-1) +: 16], 8'b0};
      ys[i] = cfg.ypts[16*(i-1) +: 16];
    end
    for (int i = 0; i < 4; i++) begin
      segspan[i] = {1'b0, xs[i+1]} - {1'b0, xs[i]};
      segdy[i]   = {1'b0, ys[i+1]} - {1'b0, ys[i]};
    end
    // past the last point: extend the last segment from point 4
    found    = 1'b0;
    sel_span = segspan[3];
    sel_dy   = segdy[3];
    sel_base = ys[4];
    sel_tref = xs[4];
    for (int i = 0; i < 4; i++) begin
      if (!found && ({8'b0, xs[i+1]} >= i_xin)) begin
        found    = 1'b1;
        sel_span = segspan[i];
        sel_dy   = segdy[i];
        sel_base = ys[i];
        sel_tref = xs[i];
      end
    end
    span_ok = !sel_span[XS_W] && (sel_span != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r  <= i_side;
      a_xin_r   <= i_xin;
      a_t_r     <= i_xin - XIN_W'(sel_tref);
      a_base_r  <= sel_base;
      a_neg_r   <= sel_dy[PT_W];
      a_dyabs_r <= sel_dy[PT_W] ? PT_W'(-sel_dy) : sel_dy[PT_W-1:0];
      a_ok_r    <= span_ok;
      // a dummy nonzero span keeps the quotient at zero when no divide is due
      a_span_r  <= span_ok ? sel_span[XS_W-1:0] : '1;
    end
  end

  // slope product, then seed the divider
  always_comb begin
    num = a_ok_r ? (NUM_W'(a_dyabs_r) * NUM_W'(a_t_r)) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= a_side_r;
      xin_r[0]  <= a_xin_r;
      base_r[0] <= a_base_r;
      neg_r[0]  <= a_neg_r;
      span_r[0] <= a_span_r;
      rem_r[0]  <= RM_W'(num[NUM_W-1:CQ_W]);
      lo_r[0]   <= num[CQ_W-1:0];
    end
  end

  for (genvar s = 0; s < CD_STG; s++) begin : g_st
    logic [RM_W-1:0] rem;
    logic [CQ_W-1:0] lo;

    always_comb begin
      rem = rem_r[s];
      lo  = lo_r[s];
      for (int k = 0; k < DIV_PER; k++) begin
        if (s * DIV_PER + k < CQ_W) begin
          rem = {rem[RM_W-2:0], lo[CQ_W-1]};
          lo  = {lo[CQ_W-2:0], 1'b0};
          if (rem >= {1'b0, span_r[s]}) begin
            rem   = rem - {1'b0, span_r[s]};
            lo[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s+1] <= side_r[s];
        xin_r[s+1]  <= xin_r[s];
        base_r[s+1] <= base_r[s];
        neg_r[s+1]  <= neg_r[s];
        span_r[s+1] <= span_r[s];
        rem_r[s+1]  <= rem;
        lo_r[s+1]   <= lo;
      end
    end
  end

  always_comb begin
    qs = $signed({2'b00, lo_r[CD_STG]});
    yq = $signed(YQ_W'(base_r[CD_STG])) + (neg_r[CD_STG] ? -qs : qs);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side_r <= side_r[CD_STG];
      f_xin_r  <= xin_r[CD_STG];
      f_yq_r   <= yq;
    end
  end

  assign o_valid = v_r[NSTG-1];
  assign o_side  = f_side_r;
  assign o_xin   = f_xin_r;
  assign o_yq    = f_yq_r;

endmodule

[hw/rtl/pbg_gain.sv]
// Curve gain normalize and divide, strength blend, per-axis scaling and clipping.
// Depends on pbg_pkg.
module pbg_gain import pbg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  pbg_cfg_t                cfg,
  input  logic                    i_valid,
  input  pbg_side_t               i_side,
  input  logic [XIN_W-1:0]        i_xin,
  input  logic signed [YQ_W-1:0]  i_yq,
  output logic                    o_valid,
  output logic [OUT_W-1:0]        o_pixels_x,
  output logic [OUT_W-1:0]        o_pixels_y,
  output logic                    o_saturated
);
  localparam int NSTG = GD_STG + 6;
  localparam int RM_W = D_W + 1;
  localparam int PX_W = CW + GAIN_W;
  localparam int M16_W = MUL_W + 11;

  logic [NSTG-1:0] v_r;

  logic [MUL_W-1:0]  m;
  logic [M16_W-1:0]  m16;
  logic [PT_W-1:0]   x1, y1;

  // stage A
  logic                     a_neg;
  logic [MAG_W-1:0]         a_mag;
  pbg_side_t                a_side_r;
  logic                     a_neg_r;
  logic [MAG_W+PT_W-1:0]    a_p1_r;
  logic [D_W-1:0]           a_d_r;

  // stage B
  pbg_side_t                b_side_r;
  logic                     b_neg_r;
  logic [P_W-1:0]           b_p_r;
  logic [D_W-1:0]           b_d_r;

  // divider, index 0 is the seed stage
  logic [P_W-1:0]           c_hi;
  logic                     c_sat;
  pbg_side_t                side_r [GD_STG+1];
  logic                     neg_r  [GD_STG+1];
  logic                     sat_r  [GD_STG+1];
  logic [D_W-1:0]           d_r    [GD_STG+1];
  logic [RM_W-1:0]          rem_r  [GD_STG+1];
  logic [GQ_W-1:0]          lo_r   [GD_STG+1];

  // curve gain, blend, output
  logic [GQ_W-1:0]           qc;
  logic signed [CG_W-1:0]    cg;
  pbg_side_t                 g_side_r;
  logic signed [CG_W-1:0]    g_cg_r;

  logic                      flat;
  logic signed [CG_W:0]      diff;
  logic signed [CG_W+STR_W+1:0] prod;
  logic signed [GAIN_W-1:0]  gain;
  pbg_side_t                 h_side_r;
  logic signed [GAIN_W-1:0]  h_gain_r;

  logic [OUT_W:0]            cx, cy;
  logic [OUT_W-1:0]          px_r, py_r;
  logic                      sat_out_r;

  function automatic logic [OUT_W:0] clip(input logic signed [PX_W-1:0] v);
    logic signed [PX_W-1:0] sh;
    logic                   fits;
    sh   = v >>> (GAIN_FRAC - OFB);
    fits = (sh[PX_W-1:OUT_W-1] == {(PX_W-OUT_W+1){sh[PX_W-1]}});
    if (fits) begin
      return {1'b0, sh[OUT_W-1:0]};
    end else if (sh[PX_W-1]) begin
      return {1'b1, 1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    m     = eff_mult(cfg);
    m16   = {m, 11'b0};
    x1    = cfg.xpts[PT_W-1:0];
    y1    = cfg.ypts[PT_W-1:0];
    a_neg = i_yq[YQ_W-1];
    a_mag = a_neg ? MAG_W'(-i_yq) : MAG_W'(i_yq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r <= i_side;
      a_neg_r  <= a_neg;
      a_p1_r   <= (MAG_W+PT_W)'(a_mag) * (MAG_W+PT_W)'(x1);
      a_d_r    <= D_W'(y1) * D_W'(i_xin);
      b_side_r <= a_side_r;
      b_neg_r  <= a_neg_r;
      b_p_r    <= P_W'(a_p1_r) * P_W'(m);
      b_d_r    <= a_d_r;
    end
  end

  // quotient of (p << 19) / d needs 29 bits unless it already exceeds the cap
  always_comb begin
    c_hi  = b_p_r >> (GQ_W - CG_SH);
    c_sat = (c_hi >= P_W'(b_d_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= b_side_r;
      neg_r[0]  <= b_neg_r;
      sat_r[0]  <= c_sat;
      d_r[0]    <= b_d_r;
      rem_r[0]  <= c_sat ? '0 : RM_W'(c_hi);
      lo_r[0]   <= {b_p_r[GQ_W-CG_SH-1:0], {CG_SH{1'b0}}};
    end
  end

  for (genvar s = 0; s < GD_STG; s++) begin : g_st
    logic [RM_W-1:0] rem;
    logic [GQ_W-1:0] lo;

    always_comb begin
      rem = rem_r[s];
      lo  = lo_r[s];
      for (int k = 0; k < DIV_PER; k++) begin
        if (s * DIV_PER + k < GQ_W) begin
          rem = {rem[RM_W-2:0], lo[GQ_W-1]};
          lo  = {lo[GQ_W-2:0], 1'b0};
          if (rem >= {1'b0, d_r[s]}) begin
            rem   = rem - {1'b0, d_r[s]};
            lo[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s+1] <= side_r[s];
        neg_r[s+1]  <= neg_r[s];
        sat_r[s+1]  <= sat_r[s];
        d_r[s+1]    <= d_r[s];
        rem_r[s+1]  <= rem;
        lo_r[s+1]   <= lo;
      end
    end
  end

  always_comb begin
    if (sat_r[GD_STG] || (lo_r[GD_STG] > (GQ_W'(1) << (GQ_W - 1)))) begin
      qc = GQ_W'(1) << (GQ_W - 1);
    end else begin
      qc = lo_r[GD_STG];
    end
    cg = neg_r[GD_STG] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end

  always_comb begin
    flat = !cfg.enable || (x1 == '0) || (y1 == '0);
    diff = (CG_W+1)'(g_cg_r) - $signed((CG_W+1)'(m16));
    prod = diff * $signed({1'b0, cfg.strength});
    if (flat) begin
      gain = $signed(GAIN_W'(m16));
    end else begin
      gain = $signed(GAIN_W'(m16)) + GAIN_W'(prod >>> 8);
    end
    cx = clip(h_side_r.dx * h_gain_r);
    cy = clip(h_side_r.dy * h_gain_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_side_r  <= side_r[GD_STG];
      g_cg_r    <= cg;
      h_side_r  <= g_side_r;
      h_gain_r  <= gain;
      px_r      <= cx[OUT_W-1:0];
      py_r      <= cy[OUT_W-1:0];
      sat_out_r <= cx[OUT_W] | cy[OUT_W];
    end
  end

  assign o_valid     = v_r[NSTG-1];
  assign o_pixels_x  = px_r;
  assign o_pixels_y  = py_r;
  assign o_saturated = sat_out_r;

endmodule

[hw/rtl/pointer_ballistics_gain.sv]
// Top level of the pointer ballistics gain block: register file and pipeline.
// Depends on pbg_pkg, pbg_root, pbg_scale, pbg_curve and pbg_gain.
//
// Usage:
//  - Input channel (in_valid / in_stall, in_move_x, in_move_y): one mouse report
//    per transfer. Output channel (out_valid / out_stall, out_pixels_x,
//    out_pixels_y, out_saturated): one result per report, in report order.
//  - A report passes through the speed root, the speed scaling divider, the curve
//    stage and the gain divider, blend and clip, in that order. The three restoring
//    dividers retire four quotient bits per stage, which sets the pipeline depth.
//  - Throughput is one report per cycle while the output is not stalled.
//  - The whole pipeline moves as one: while a result sits in the output
//    register with out_stall high, every stage holds and in_stall is raised.
//    Nothing is dropped or repeated; bubbles travel as cleared valid bits.
//  - Reset (rst_n low, synchronous) clears all valid bits and loads the
//    register defaults. Write configuration only with the pipeline drained.
//  - Register port: APB-style, register i at byte address 8*i, 64-bit data,
//    pready tied high, zero wait states. Index 7 reads zero; paddr[2:0] is ignored.
module pointer_ballistics_gain import pbg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [CW-1:0]  in_move_x,
  input  logic signed [CW-1:0]  in_move_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [OUT_W-1:0] out_pixels_x,
  output logic signed [OUT_W-1:0] out_pixels_y,
  output logic                  out_saturated,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [5:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  pbg_cfg_t              cfg_r;
  logic                  wr_en;
  logic [RIDX_W-1:0]     ridx;
  logic                  adv;

  pbg_side_t             in_side, r_side, s_side, c_side;
  logic                  r_valid, s_valid, c_valid, g_valid;
  logic [RT_W-1:0]       r_root;
  logic [XIN_W-1:0]      s_xin, c_xin;
  logic signed [YQ_W-1:0] c_yq;
  logic [OUT_W-1:0]      g_px, g_py;

  // Register file: write in the access phase of a write transfer.
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign ridx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable   <= 1'b0;
      cfg_r.mult     <= MUL_W'(32);
      cfg_r.divisor  <= DIV_W'(256);
      cfg_r.strength <= STR_W'(256);
      cfg_r.xpts     <= '0;
      cfg_r.ypts     <= '0;
      cfg_r.yorg     <= '0;
    end else if (wr_en) begin
      unique case (ridx)
        REG_ENABLE:   cfg_r.enable   <= pwdata[0];
        REG_MULT:     cfg_r.mult     <= pwdata[MUL_W-1:0];
        REG_DIVISOR:  cfg_r.divisor  <= pwdata[DIV_W-1:0];
        REG_STRENGTH: cfg_r.strength <= pwdata[STR_W-1:0];
        REG_XPTS:     cfg_r.xpts     <= pwdata;
        REG_YPTS:     cfg_r.ypts     <= pwdata;
        REG_YORG:     cfg_r.yorg     <= pwdata[PT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ENABLE:   prdata = 64'(cfg_r.enable);
      REG_MULT:     prdata = 64'(cfg_r.mult);
      REG_DIVISOR:  prdata = 64'(cfg_r.divisor);
      REG_STRENGTH: prdata = 64'(cfg_r.strength);
      REG_XPTS:     prdata = cfg_r.xpts;
      REG_YPTS:     prdata = cfg_r.ypts;
      REG_YORG:     prdata = 64'(cfg_r.yorg);
      default:      prdata = '0;
    endcase
  end

  // Advance every stage unless a finished result is held by the receiver.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  assign in_side.dx = in_move_x;
  assign in_side.dy = in_move_y;

  pbg_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .i_valid (in_valid),
    .i_side  (in_side),
    .o_valid (r_valid),
    .o_side  (r_side),
    .o_root  (r_root)
  );

  pbg_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg_r),
    .i_valid (r_valid),
    .i_side  (r_side),
    .i_root  (r_root),
    .o_valid (s_valid),
    .o_side  (s_side),
    .o_xin   (s_xin)
  );

  pbg_curve u_curve (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg_r),
    .i_valid (s_valid),
    .i_side  (s_side),
    .i_xin   (s_xin),
    .o_valid (c_valid),
    .o_side  (c_side),
    .o_xin   (c_xin),
    .o_yq    (c_yq)
  );

  pbg_gain u_gain (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .cfg         (cfg_r),
    .i_valid     (c_valid),
    .i_side      (c_side),
    .i_xin       (c_xin),
    .i_yq        (c_yq),
    .o_valid     (g_valid),
    .o_pixels_x  (g_px),
    .o_pixels_y  (g_py),
    .o_saturated (out_saturated)
  );

  assign out_valid    = g_valid;
  assign out_pixels_x = $signed(g_px);
  assign out_pixels_y = $signed(g_py);

endmodule

[hw/rtl/pbg_checker.sv]
// Port-level checks for pointer_ballistics_gain, attached by the bind below.
// Depends only on the top-level ports.
module pbg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pixels_x,
  input logic signed [31:0] out_pixels_y,
  input logic               out_saturated
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixels_x)
      && $stable(out_pixels_y) && $stable(out_saturated))
    else $error("stalled result changed");

  // Stall the input only behind a held result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // Drop all results on reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A clipped result sits at a range limit.
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_pixels_x == 32'sh7FFF_FFFF || out_pixels_x == 32'sh8000_0000 ||
      out_pixels_y == 32'sh7FFF_FFFF || out_pixels_y == 32'sh8000_0000)
    else $error("clip flag without a limit value");

endmodule

bind pointer_ballistics_gain pbg_checker u_pbg_checker (.*);

[dv/pointer_ballistics_gain_test.sv]
// Testbench for pointer_ballistics_gain: random mouse reports under random idling,
// checked against an in-bench fixed-point model of the gain path.
// Depends on pbg_pkg and the pointer_ballistics_gain RTL.
module pointer_ballistics_gain_test;
  import pbg_pkg::*;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sat;
  } motion_t;

  // Gain scoreboard: predicts the pixel motion of each report and checks results.
  class motion_scoreboard;
    bit        enable;
    bit [6:0]  mult;
    bit [15:0] divisor;
    bit [8:0]  strength;
    bit [63:0] xpts;
    bit [63:0] ypts;
    bit [15:0] yorg;
    motion_t   pending[$];
    int        errors;

    function void set_defaults();
      enable = 0; mult = 32; divisor = 256; strength = 256;
      xpts = 0; ypts = 0; yorg = 0;
    endfunction

    function longint floor_div_pow2(longint v, int sh);
      return v >>> sh;
    endfunction

    function bit [63:0] speed_root(bit [63:0] sq);
      bit [63:0] r, rem, t, pair;
      r = 0; rem = 0;
      for (int i = 39; i >= 0; i--) begin
        pair = (i >= 8) ? ((sq >> (2 * (i - 8))) & 3) : 0;
        rem = (rem << 2) | pair;
        t = (r << 2) | 1;
        if (rem >= t) begin
          rem -= t;
          r = (r << 1) | 1;
        end else begin
          r = r << 1;
        end
      end
      return r;
    endfunction

    function longint curve_y(longint xin);
      longint xs[5], ys[5], span;
      xs[0] = 0;
      ys[0] = yorg;
      for (int i = 1; i < 5; i++) begin
        xs[i] = longint'(xpts[16*(i-1) +: 16]) << 8;
        ys[i] = longint'(ypts[16*(i-1) +: 16]);
      end
      for (int i = 0; i < 4; i++) begin
        if (xin <= xs[i+1]) begin
          span = xs[i+1] - xs[i];
          if (span <= 0) return ys[i];
          return ys[i] + (ys[i+1] - ys[i]) * (xin - xs[i]) / span;
        end
      end
      span = xs[4] - xs[3];
      if (span <= 0) return ys[4];
      return ys[4] + (ys[4] - ys[3]) * (xin - xs[4]) / span;
    endfunction

    function longint clip32(longint v, ref bit sat);
      if (v > 64'sd2147483647) begin
        sat = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // Note an accepted report and queue its expected motion.
    function void note_report(logic signed [15:0] dx, logic signed [15:0] dy);
      motion_t   e;
      longint    m, m16, gain, yq, cg;
      bit [63:0] x1, y1, ax, ay, c8, d, xin, mag, q;
      bit [127:0] num;
      bit        sat;
      sat = 0;
      if (dx == 0 && dy == 0) begin
        e.px = 0; e.py = 0; e.sat = 0;
        pending.push_back(e);
        return;
      end
      m = (mult == 0) ? 1 : mult;
      m16 = m << 11;
      x1 = xpts[15:0];
      y1 = ypts[15:0];
      if (!enable || x1 == 0 || y1 == 0) begin
        gain = m16;
      end else begin
        ax = (dx < 0) ? -longint'(dx) : dx;
        ay = (dy < 0) ? -longint'(dy) : dy;
        c8 = speed_root(ax * ax + ay * ay);
        d = (divisor == 0) ? 1 : divisor;
        xin = c8 * m * 2048 / d;
        if (xin > 64'hFFFF_FFFF) xin = 64'hFFFF_FFFF;
        yq = curve_y(longint'(xin));
        mag = (yq < 0) ? -yq : yq;
        num = 128'(mag * x1) * 128'(m << 19);
        if (y1 * xin == 0) q = 1 << 28;
        else begin
          num = num / 128'(y1 * xin);
          q = (num > (1 << 28)) ? (1 << 28) : num[63:0];
        end
        cg = (yq < 0) ? -longint'(q) : longint'(q);
        gain = m16 + floor_div_pow2((cg - m16) * longint'(strength), 8);
      end
      e.px = 32'(clip32(floor_div_pow2(longint'(dx) * gain, 8), sat));
      e.py = 32'(clip32(floor_div_pow2(longint'(dy) * gain, 8), sat));
      e.sat = sat;
      pending.push_back(e);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_motion(logic signed [31:0] px, logic signed [31:0] py, logic sat);
      motion_t e;
      if (pending.size() == 0) begin
        $error("unexpected result px=%0d py=%0d", px, py);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (px !== e.px) begin
        $error("pixels_x expected %0d actual %0d", e.px, px);
        errors++;
      end
      if (py !== e.py) begin
        $error("pixels_y expected %0d actual %0d", e.py, py);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated expected %0d actual %0d", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 42;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CW-1:0] in_move_x = 0;
  logic signed [CW-1:0] in_move_y = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [OUT_W-1:0] out_pixels_x, out_pixels_y;
  logic out_saturated;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = 0;
  logic [63:0] pwdata = 0;
  logic [63:0] prdata;
  logic pready;

  pointer_ballistics_gain DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_move_x, .in_move_y,
    .out_valid, .out_stall, .out_pixels_x, .out_pixels_y, .out_saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  motion_scoreboard board = new();
  int send_idle_pct = 0;   // sender gap chance, percent
  int recv_stall_pct = 0;  // receiver stall chance, percent
  int hold_off = 0;        // cycles of forced receiver stall still to run
  int quiet_cycles = 0;
  bit done = 0;

  // Receiver: stall at random, or hold off for a counted stretch.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_motion(out_pixels_x, out_pixels_y, out_saturated);
  end

  // Watchdog: count cycles with no transfer on either channel and no register access.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n || done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Write one register: setup cycle, then access cycle.
  task automatic write_reg(logic [RIDX_W-1:0] idx, logic [63:0] value);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 6'(idx) << 3; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_ENABLE:   board.enable = value[0];
      REG_MULT:     board.mult = value[6:0];
      REG_DIVISOR:  board.divisor = value[15:0];
      REG_STRENGTH: board.strength = value[8:0];
      REG_XPTS:     board.xpts = value;
      REG_YPTS:     board.ypts = value;
      REG_YORG:     board.yorg = value[15:0];
      default: ;
    endcase
  endtask

  // Send one report; hold it until the transfer completes.
  task automatic send_report(logic signed [15:0] dx, logic signed [15:0] dy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_move_x <= dx; in_move_y <= dy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_report(dx, dy);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_count();
    case ($urandom_range(5))
      0: return 16'($urandom_range(7)) - 16'sd3;
      1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      2: return 16'($urandom_range(255)) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sorted curve with random content; occasionally broken ordering.
  function automatic logic [63:0] rand_xpts();
    logic [15:0] p[4];
    int acc;
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      acc += $urandom_range(1, 4000);
      p[i] = 16'(acc);
    end
    if ($urandom_range(5) == 0) return {$urandom, $urandom};
    return {p[3], p[2], p[1], p[0]};
  endfunction

  function automatic logic [63:0] rand_ypts();
    return {16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
            16'($urandom_range(1, 65535))};
  endfunction

  task automatic random_config();
    write_reg(REG_ENABLE, $urandom_range(3) != 0);
    write_reg(REG_MULT, $urandom_range(127));
    case ($urandom_range(3))
      0: write_reg(REG_DIVISOR, 0);
      1: write_reg(REG_DIVISOR, 16'hFFFF);
      default: write_reg(REG_DIVISOR, $urandom_range(1, 4096));
    endcase
    write_reg(REG_STRENGTH, $urandom_range(511));
    write_reg(REG_XPTS, rand_xpts());
    write_reg(REG_YPTS, rand_ypts());
    write_reg(REG_YORG, $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    board.set_defaults();
    @(posedge clk);

    // Directed: flat default gain at the count extremes and a zero report.
    send_report(0, 0);
    send_report(16'sh7FFF, 16'sh8000);
    send_report(1, -1);
    send_report(16'sh8000, 0);
    drain();
    // Accelerated: multiplier 112, zero multiplier, zero divisor, unsorted points.
    write_reg(REG_ENABLE, 1);
    write_reg(REG_MULT, 112);
    write_reg(REG_DIVISOR, 1);
    write_reg(REG_STRENGTH, 511);
    write_reg(REG_XPTS, 64'h4000_3000_2000_0100);
    write_reg(REG_YPTS, 64'hFFFF_8000_4000_0040);
    write_reg(REG_YORG, 16'hFFFF);
    send_report(16'sh7FFF, 16'sh7FFF);
    send_report(3, 4);
    send_report(-200, 77);
    drain();
    write_reg(REG_MULT, 0);
    write_reg(REG_DIVISOR, 0);
    write_reg(REG_XPTS, 64'h0001_0500_0200_0300);
    write_reg(REG_STRENGTH, 0);
    send_report(16'sh8000, 16'sh8000);
    send_report(5, 0);
    send_report(-1, 40);
    drain();
    // Flat selection through a zero first y point.
    write_reg(REG_YPTS, 64'h1234_5678_9ABC_0000);
    write_reg(REG_STRENGTH, 256);
    send_report(100, -100);
    send_report(16'sh7FFF, 1);
    drain();

    // Random phases over the idling patterns.
    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      random_config();
      if (phase == 5) hold_off = 150;  // fill the pipeline so the input stalls
      for (int n = 0; n < 76; n++) begin
        send_report(rand_count(), rand_count());
        if (phase == 9 && n == 40) drain();  // pause until all results are in
      end
      drain();
    end

    done = 1;
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[pointer_ballistics_gain.f]
hw/rtl/pbg_pkg.sv
hw/rtl/pbg_root.sv
hw/rtl/pbg_scale.sv
hw/rtl/pbg_curve.sv
hw/rtl/pbg_gain.sv
hw/rtl/pointer_ballistics_gain.sv
hw/rtl/pbg_checker.sv
dv/pointer_ballistics_gain_test.sv
